// File: hdl/rbw_pkg.sv
// Shared constants and types for the rolling beta window block.
// Used by the stream interfaces, the datapath modules, the top level and the checker.
package rbw_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int RETURN_BITS = 16;

  localparam int PTR_W     = $clog2(MAX_WINDOW);
  localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
  localparam int PROD_W    = 2 * RETURN_BITS;
  localparam int SUM_W     = PROD_W + PTR_W;
  localparam int BETA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = BETA_W - FRAC_BITS;
  localparam int CNT_W     = $clog2(BETA_W);

  localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(252);
  localparam logic [WIN_W-1:0]  WINDOW_MIN   = WIN_W'(2);
  localparam logic [WIN_W-1:0]  WINDOW_MAX   = WIN_W'(MAX_WINDOW);
  localparam logic [BETA_W-1:0] BETA_POS_SAT = {1'b0, {(BETA_W-1){1'b1}}};
  localparam logic [BETA_W-1:0] BETA_NEG_SAT = {1'b1, {(BETA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [RETURN_BITS-1:0] asset_return;
    logic signed [RETURN_BITS-1:0] market_return;
    logic                          series_start;
  } rbw_in_t;

  typedef struct packed {
    logic signed [BETA_W-1:0] beta;
    logic                     beta_valid;
    logic                     zero_variance;
    logic                     beta_saturated;
  } rbw_out_t;

  typedef struct packed {
    logic signed [RETURN_BITS-1:0] asset;
    logic signed [RETURN_BITS-1:0] market;
  } rbw_pair_t;

  // One multiply-accumulate request to the shared MAC.
  typedef struct packed {
    logic                          valid;
    logic                          sel_sq;
    logic                          sub;
    logic signed [RETURN_BITS-1:0] op_a;
    logic signed [RETURN_BITS-1:0] op_b;
  } rbw_mac_cmd_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [BETA_W-1:0] beta;
  } rbw_div_rsp_t;

endpackage

// File: hdl/rbw_if.sv
// Valid/ready stream interfaces for the input, result and configuration channels.
// Depends on rbw_pkg for the payload types.
interface rbw_in_if import rbw_pkg::*; ();
  logic    valid;
  logic    ready;
  rbw_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbw_out_if import rbw_pkg::*; ();
  logic     valid;
  logic     ready;
  rbw_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbw_cfg_if import rbw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/rolling_beta_window_top.sv
// Rolling-window beta top level: sequencer around the history memory, MAC and divider.
// Depends on rbw_pkg, rbw_if, rbw_hist, rbw_mac and rbw_div.
// Each request retires the oldest pair once the window is full, adds the new pair, and is
// divided only with a full window and nonzero variance. Throughput: one request in flight,
// the next taken the cycle after its result is registered; the 32-step divider sets the pace.
// Reset clears sums, count, pointer and sets window 252.
module rolling_beta_window_top import rbw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbw_in_if.sink    req_i,
  rbw_out_if.source res_o,
  rbw_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_OLD_PR, S_OLD_SQ, S_NEW_PR, S_NEW_SQ, S_SETTLE, S_CHECK, S_DIV, S_OUT
  } seq_state_e;

  seq_state_e state_q;

  logic [WIN_W-1:0] win_len_q;
  logic [PTR_W-1:0] ptr_q;
  logic [WIN_W-1:0] seen_q;
  logic signed [RETURN_BITS-1:0] asset_q, market_q;
  rbw_out_t         res_q, out_q;
  logic             out_valid_q;

  logic [WIN_W-1:0] win;
  logic             accept;
  logic             start;
  logic [PTR_W-1:0] ptr_eff;
  logic [WIN_W-1:0] seen_eff;
  logic [WIN_W-1:0] ptr_inc;
  logic [PTR_W-1:0] ptr_next;
  logic [WIN_W-1:0] seen_next;
  logic             win_full;
  logic             out_load;

  rbw_pair_t               old_pair, new_pair;
  rbw_mac_cmd_t            mac_cmd;
  logic signed [SUM_W-1:0] prod_sum, sq_sum;
  logic                    div_start;
  rbw_div_rsp_t            div_rsp;

  // Window register; writes must arrive only while idle (the block does not enforce this), so take them at once.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WINDOW_RESET;
    end else if (cfg_i.valid) begin
      win_len_q <= cfg_i.data;
    end
  end

  // Clamp the window into its legal range.
  always_comb begin
    if (win_len_q < WINDOW_MIN) begin
      win = WINDOW_MIN;
    end else if (win_len_q > WINDOW_MAX) begin
      win = WINDOW_MAX;
    end else begin
      win = win_len_q;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);
  assign start       = req_i.data.series_start;

  // Pointer and count as seen by this request: series start clears them,
  // a shortened window wraps the pointer and clamps the count.
  always_comb begin
    if (start || (WIN_W'(ptr_q) >= win)) begin
      ptr_eff = '0;
    end else begin
      ptr_eff = ptr_q;
    end
    if (start) begin
      seen_eff = '0;
    end else if (seen_q > win) begin
      seen_eff = win;
    end else begin
      seen_eff = seen_q;
    end
    ptr_inc   = WIN_W'(ptr_q) + 1'b1;
    ptr_next  = (ptr_inc == win) ? '0 : ptr_inc[PTR_W-1:0];
    seen_next = (seen_q < win) ? seen_q + 1'b1 : seen_q;
    win_full  = (seen_next == win);
  end

  // Feed the shared MAC: retire the oldest pair first, then add the new one.
  always_comb begin
    mac_cmd = '0;
    case (state_q)
      S_OLD_PR: begin
        mac_cmd = '{valid: 1'b1, sel_sq: 1'b0, sub: 1'b1,
                    op_a: old_pair.asset, op_b: old_pair.market};
      end
      S_OLD_SQ: begin
        mac_cmd = '{valid: 1'b1, sel_sq: 1'b1, sub: 1'b1,
                    op_a: old_pair.market, op_b: old_pair.market};
      end
      S_NEW_PR: begin
        mac_cmd = '{valid: 1'b1, sel_sq: 1'b0, sub: 1'b0, op_a: asset_q, op_b: market_q};
      end
      S_NEW_SQ: begin
        mac_cmd = '{valid: 1'b1, sel_sq: 1'b1, sub: 1'b0, op_a: market_q, op_b: market_q};
      end
      default: mac_cmd = '0;
    endcase
  end

  assign new_pair  = '{asset: asset_q, market: market_q};
  assign div_start = (state_q == S_CHECK) && win_full && (sq_sum != '0);

  // Load the output register once it is free or being drained this cycle.
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || res_o.ready);

  rbw_hist u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == S_NEW_PR),
    .wr_addr_i (ptr_q),
    .wr_data_i (new_pair),
    .rd_en_i   (accept),
    .rd_addr_i (ptr_eff),
    .rd_data_o (old_pair)
  );

  rbw_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (accept && start),
    .cmd_i      (mac_cmd),
    .prod_sum_o (prod_sum),
    .sq_sum_o   (sq_sum)
  );

  rbw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_sum),
    .den_i   (sq_sum),
    .rsp_o   (div_rsp)
  );

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            asset_q  <= req_i.data.asset_return;
            market_q <= req_i.data.market_return;
            ptr_q    <= ptr_eff;
            seen_q   <= seen_eff;
            state_q  <= (seen_eff == win) ? S_OLD_PR : S_NEW_PR;
          end
        end
        S_OLD_PR: state_q <= S_OLD_SQ;
        S_OLD_SQ: state_q <= S_NEW_PR;
        S_NEW_PR: state_q <= S_NEW_SQ;
        // Let the last product land in its sum.
        S_NEW_SQ: state_q <= S_SETTLE;
        S_SETTLE: state_q <= S_CHECK;
        S_CHECK: begin
          ptr_q  <= ptr_next;
          seen_q <= seen_next;
          if (!win_full) begin
            res_q   <= '0;
            state_q <= S_OUT;
          end else if (sq_sum == '0) begin
            res_q   <= '{beta: '0, beta_valid: 1'b1, zero_variance: 1'b1,
                         beta_saturated: 1'b0};
            state_q <= S_OUT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_q   <= '{beta: div_rsp.beta, beta_valid: 1'b1, zero_variance: 1'b0,
                         beta_saturated: div_rsp.sat};
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free or being drained.
          if (out_load) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

endmodule

// File: hdl/rbw_hist.sv
// Return history memory: one write port, one registered read port.
// Depends on rbw_pkg.
module rbw_hist import rbw_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [PTR_W-1:0] wr_addr_i,
  input  rbw_pair_t        wr_data_i,
  input  logic             rd_en_i,
  input  logic [PTR_W-1:0] rd_addr_i,
  output rbw_pair_t        rd_data_o
);

  rbw_pair_t mem_q [MAX_WINDOW];
  rbw_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/rbw_mac.sv
// Shared multiply-accumulate unit holding the product sum and the market square sum.
// Depends on rbw_pkg. Multiply in one stage, accumulate in the next.
module rbw_mac import rbw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  rbw_mac_cmd_t            cmd_i,
  output logic signed [SUM_W-1:0] prod_sum_o,
  output logic signed [SUM_W-1:0] sq_sum_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     v1_q, sel1_q, sub1_q;
  logic signed [SUM_W-1:0]  prod_sum_q, sq_sum_q;
  logic signed [SUM_W-1:0]  ext, addend, base, sum_new;

  assign prod_d = PROD_W'($signed(cmd_i.op_a)) * PROD_W'($signed(cmd_i.op_b));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sel1_q <= cmd_i.sel_sq;
    sub1_q <= cmd_i.sub;
  end

  always_comb begin
    ext     = SUM_W'(prod_q);
    addend  = sub1_q ? -ext : ext;
    base    = sel1_q ? sq_sum_q : prod_sum_q;
    sum_new = base + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      prod_sum_q <= '0;
      sq_sum_q   <= '0;
    end else if (clear_i) begin
      v1_q       <= 1'b0;
      prod_sum_q <= '0;
      sq_sum_q   <= '0;
    end else begin
      v1_q <= cmd_i.valid;
      if (v1_q) begin
        if (sel1_q) begin
          sq_sum_q <= sum_new;
        end else begin
          prod_sum_q <= sum_new;
        end
      end
    end
  end

  assign prod_sum_o = prod_sum_q;
  assign sq_sum_o   = sq_sum_q;

endmodule

// File: hdl/rbw_div.sv
// Radix-2 restoring divider giving a saturated signed Q16.16 quotient, one bit per cycle.
// Depends on rbw_pkg.
module rbw_div import rbw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] num_i,
  input  logic signed [SUM_W-1:0] den_i,
  output rbw_div_rsp_t            rsp_o
);

  typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_FIN} div_state_e;

  div_state_e        state_q;
  logic [SUM_W-1:0]  an_q, ad_q, rem_q;
  logic              neg_q, ovf_q;
  logic [BETA_W-1:0] shift_q, quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q, sat_q;
  logic [BETA_W-1:0] beta_q;

  logic [SUM_W-1:0]  num_u, den_u, an_d, ad_d, hi;
  logic [SUM_W:0]    rem_sh, rem_sub;
  logic              ge;

  always_comb begin
    num_u   = num_i;
    den_u   = den_i;
    an_d    = num_u[SUM_W-1] ? (~num_u + 1'b1) : num_u;
    ad_d    = den_u[SUM_W-1] ? (~den_u + 1'b1) : den_u;
    hi      = an_q >> INT_BITS;
    rem_sh  = {rem_q, shift_q[BETA_W-1]};
    rem_sub = rem_sh - {1'b0, ad_q};
    ge      = rem_sh >= {1'b0, ad_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            an_q    <= an_d;
            ad_q    <= ad_d;
            neg_q   <= num_u[SUM_W-1] ^ den_u[SUM_W-1];
            state_q <= D_PREP;
          end
        end
        D_PREP: begin
          // Integer part too large: skip the bit loop.
          rem_q   <= hi;
          shift_q <= {an_q[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
          ovf_q   <= hi >= ad_q;
          cnt_q   <= '0;
          state_q <= (hi >= ad_q) ? D_FIN : D_RUN;
        end
        D_RUN: begin
          rem_q   <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
          quo_q   <= {quo_q[BETA_W-2:0], ge};
          shift_q <= {shift_q[BETA_W-2:0], 1'b0};
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(BETA_W - 1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          done_q  <= 1'b1;
          state_q <= D_IDLE;
          if (ovf_q) begin
            sat_q  <= 1'b1;
            beta_q <= neg_q ? BETA_NEG_SAT : BETA_POS_SAT;
          end else if (!neg_q) begin
            sat_q  <= quo_q[BETA_W-1];
            beta_q <= quo_q[BETA_W-1] ? BETA_POS_SAT : quo_q;
          end else begin
            sat_q  <= quo_q > BETA_NEG_SAT;
            beta_q <= (quo_q > BETA_NEG_SAT) ? BETA_NEG_SAT : (~quo_q + 1'b1);
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.beta = beta_q;

endmodule

// File: hdl/rbw_checker.sv
// Port-level checks for the rolling beta window top level, attached by bind.
// Depends on rbw_pkg and rolling_beta_window_top.
module rbw_checker import rbw_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [BETA_W-1:0] res_beta_i,
  input logic              res_beta_valid_i,
  input logic              res_zero_var_i,
  input logic              res_sat_i
);

  // One request at a time: ready drops right after a request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_beta_valid_i |->
      res_beta_i == '0 && !res_zero_var_i && !res_sat_i)
    else $error("partial window result carries data or flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_zero_var_i |-> res_beta_valid_i && res_beta_i == '0 && !res_sat_i)
    else $error("zero variance result is not a clean zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_sat_i |-> res_beta_i == BETA_POS_SAT || res_beta_i == BETA_NEG_SAT)
    else $error("saturated beta is not at a range limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_beta_i) && $stable(res_beta_valid_i)
      && $stable(res_zero_var_i) && $stable(res_sat_i))
    else $error("stalled result changed");

endmodule

bind rolling_beta_window_top rbw_checker u_rbw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_beta_i       (res_o.data.beta),
  .res_beta_valid_i (res_o.data.beta_valid),
  .res_zero_var_i   (res_o.data.zero_variance),
  .res_sat_i        (res_o.data.beta_saturated)
);
